@@ rtl/bme_pkg.sv @@
package bme_pkg;

	localparam int VAL_W         = 32;
	localparam int WID_W         = 31;
	localparam int OUT_FRAC_BITS = 15;
	localparam int OUT_W         = OUT_FRAC_BITS + 1;
	localparam int RATIO_BITS    = 20;
	localparam int ACC_BITS      = 30;
	// The distance is below five widths, so the quotient stays under 8 << RATIO_BITS.
	localparam int PRE_BITS      = 3;
	localparam int Q_W           = RATIO_BITS + PRE_BITS;
	localparam int REM_W         = WID_W;
	localparam int N_W           = 5;
	localparam int Y_W           = ACC_BITS + 1;
	localparam int ADDR_W        = 3;

	localparam logic [OUT_W-1:0] ONE       = OUT_W'(1) << OUT_FRAC_BITS;
	localparam logic [WID_W-1:0] WIDTH_RST = WID_W'(65536000);

	typedef enum logic [1:0] {
		MODE_BELL       = 2'd0,
		MODE_FLAT_ABOVE = 2'd1,
		MODE_FLAT_BELOW = 2'd2
	} bme_mode_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_CENTER    = 3'd0,
		REG_CENTER_OK = 3'd1,
		REG_LEFT_W    = 3'd2,
		REG_RIGHT_W   = 3'd3,
		REG_MODE      = 3'd4
	} bme_reg_t;

	typedef struct packed {
		logic [VAL_W-1:0] center;
		logic             center_ok;
		logic [WID_W-1:0] wl;
		logic [WID_W-1:0] wr;
		bme_mode_t        mode;
	} bme_cfg_t;

	// Per-word control: valid, result already decided (zero or one), side in use.
	typedef struct packed {
		logic vld;
		logic forced;
		logic one;
		logic upper;
	} bme_ctl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] acc;
		logic [63:0] root;
		logic [63:0] probe;
		acc   = v;
		root  = '0;
		probe = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (acc >= root + probe) begin
				acc  = acc - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// Factor 2^-(2^-k) in Q30, built by repeated square roots starting from one half.
	function automatic logic [ACC_BITS-1:0] root_tap(input int k);
		logic [63:0] t;
		t = 64'(1) << (ACC_BITS - 1);
		for (int i = 1; i <= RATIO_BITS; i++) begin
			if (i <= k) begin
				t = isqrt64(t << ACC_BITS);
			end
		end
		return t[ACC_BITS-1:0];
	endfunction

endpackage

@@ rtl/bme_front.sv @@
module bme_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic [bme_pkg::VAL_W-1:0] in_value,
	input  logic                    in_ok,
	input  bme_pkg::bme_cfg_t       cfg,
	output logic [bme_pkg::VAL_W-1:0] distance,
	output bme_pkg::bme_ctl_t       ctl
);
	import bme_pkg::*;

	logic             above;
	logic             below;
	logic             flat;
	logic [VAL_W:0]   diff;
	bme_ctl_t         ctl_n1;
	logic [VAL_W:0]   neg;
	logic [VAL_W-1:0] dmag;
	logic [WID_W-1:0] wsel;
	logic [WID_W+2:0] w5;
	bme_ctl_t         ctl_n3;

	logic [VAL_W:0]   diff_s1;
	bme_ctl_t         ctl_s1;
	logic [VAL_W-1:0] d_s2;
	logic [WID_W+2:0] w5_s2;
	bme_ctl_t         ctl_s2;
	logic [VAL_W-1:0] d_s3;
	bme_ctl_t         ctl_s3;

	always_comb begin
		above = $signed(in_value) > $signed(cfg.center);
		below = $signed(in_value) < $signed(cfg.center);
		diff  = {in_value[VAL_W-1], in_value} - {cfg.center[VAL_W-1], cfg.center};
		flat  = !(above || below) || (above && cfg.mode == MODE_FLAT_ABOVE)
			|| (below && cfg.mode == MODE_FLAT_BELOW);
		ctl_n1.vld    = in_vld;
		ctl_n1.forced = !in_ok || !cfg.center_ok || flat;
		ctl_n1.one    = in_ok && cfg.center_ok;
		ctl_n1.upper  = above;
	end

	always_comb begin
		neg  = -diff_s1;
		dmag = diff_s1[VAL_W] ? neg[VAL_W-1:0] : diff_s1[VAL_W-1:0];
		wsel = ctl_s1.upper ? cfg.wr : cfg.wl;
		w5   = {1'b0, wsel, 2'b00} + {3'b000, wsel};
	end

	// Five widths or more away rounds to zero; a zero width lands here as well.
	always_comb begin
		ctl_n3 = ctl_s2;
		if (!ctl_s2.forced && ({2'b00, d_s2} >= w5_s2)) begin
			ctl_n3.forced = 1'b1;
			ctl_n3.one    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_n1;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_n3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff;
			d_s2    <= dmag;
			w5_s2   <= w5;
			d_s3    <= d_s2;
		end
	end

	assign distance = d_s3;
	assign ctl      = ctl_s3;

endmodule

@@ rtl/bme_div.sv @@
module bme_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  bme_pkg::bme_cfg_t       cfg,
	input  logic [bme_pkg::VAL_W-1:0] distance,
	input  bme_pkg::bme_ctl_t       ctl_in,
	output logic [bme_pkg::Q_W-1:0] ratio,
	output bme_pkg::bme_ctl_t       ctl_out
);
	import bme_pkg::*;

	logic [REM_W-1:0]    rem_s [1:Q_W];
	logic [Q_W-1:0]      q_s   [1:Q_W];
	logic [PRE_BITS-1:0] lo_s  [1:Q_W];
	bme_ctl_t            ctl_s [1:Q_W];

	// One quotient bit per stage; the remainder stays below the width for words not already decided.
	for (genvar j = 0; j < Q_W; j++) begin : g_step
		logic [REM_W-1:0]    rem_i;
		logic [Q_W-1:0]      q_i;
		logic [PRE_BITS-1:0] lo_i;
		bme_ctl_t            ctl_i;
		logic [REM_W:0]      w_ext;
		logic [REM_W:0]      trial;
		logic                ge;

		if (j == 0) begin : g_first
			assign rem_i = REM_W'(distance[VAL_W-1:PRE_BITS]);
			assign q_i   = '0;
			assign lo_i  = distance[PRE_BITS-1:0];
			assign ctl_i = ctl_in;
		end else begin : g_next
			assign rem_i = rem_s[j];
			assign q_i   = q_s[j];
			assign lo_i  = lo_s[j];
			assign ctl_i = ctl_s[j];
		end

		always_comb begin
			w_ext = {1'b0, ctl_i.upper ? cfg.wr : cfg.wl};
			trial = {rem_i, lo_i[PRE_BITS-1]};
			ge    = trial >= w_ext;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? REM_W'(trial - w_ext) : trial[REM_W-1:0];
				q_s[j+1]   <= {q_i[Q_W-2:0], ge};
				lo_s[j+1]  <= {lo_i[PRE_BITS-2:0], 1'b0};
			end
		end
	end

	assign ratio   = q_s[Q_W];
	assign ctl_out = ctl_s[Q_W];

	logic [WID_W-1:0] w_last;
	assign w_last = ctl_s[Q_W].upper ? cfg.wr : cfg.wl;

	a_rem_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[Q_W].vld && !ctl_s[Q_W].forced |-> rem_s[Q_W] < w_last)
		else $error("divider remainder not below the width");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[Q_W].vld && !ctl_s[Q_W].forced |-> q_s[Q_W] < Q_W'(5 << RATIO_BITS))
		else $error("ratio reached five widths on a live word");

endmodule

@@ rtl/bme_exp.sv @@
module bme_exp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [bme_pkg::Q_W-1:0]   ratio,
	input  bme_pkg::bme_ctl_t         ctl_in,
	output logic [bme_pkg::OUT_W-1:0] membership,
	output logic                      out_vld
);
	import bme_pkg::*;

	logic [2*Q_W-1:0]      sq;
	logic [N_W-1:0]        n_s1;
	logic [RATIO_BITS-1:0] f_s1;
	bme_ctl_t              ctl_s1;

	logic [Y_W-1:0]        y_s   [1:RATIO_BITS];
	logic [RATIO_BITS-1:0] f_s   [1:RATIO_BITS];
	logic [N_W-1:0]        n_s   [1:RATIO_BITS];
	bme_ctl_t              ctl_s [1:RATIO_BITS];

	logic [Y_W-1:0]        ys;
	logic [Y_W:0]          rsum;
	logic [OUT_W-1:0]      mem_n;
	logic [OUT_W-1:0]      out_s;
	logic                  vld_out_s;

	// Square of the ratio, split into integer part n and fraction f.
	assign sq = ratio * ratio;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= sq[2*RATIO_BITS+N_W-1:2*RATIO_BITS];
			f_s1 <= sq[2*RATIO_BITS-1:RATIO_BITS];
		end
	end

	// 0.5^f as a product of roots of one half, one fraction bit per stage.
	for (genvar k = 1; k <= RATIO_BITS; k++) begin : g_tap
		localparam logic [ACC_BITS-1:0] TAP = root_tap(k);
		logic [Y_W-1:0]          y_i;
		logic [RATIO_BITS-1:0]   f_i;
		logic [N_W-1:0]          n_i;
		bme_ctl_t                ctl_i;
		logic [Y_W+ACC_BITS-1:0] prod;

		if (k == 1) begin : g_first
			assign y_i   = Y_W'(1) << ACC_BITS;
			assign f_i   = f_s1;
			assign n_i   = n_s1;
			assign ctl_i = ctl_s1;
		end else begin : g_next
			assign y_i   = y_s[k-1];
			assign f_i   = f_s[k-1];
			assign n_i   = n_s[k-1];
			assign ctl_i = ctl_s[k-1];
		end

		assign prod = y_i * TAP;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				y_s[k] <= f_i[RATIO_BITS-k] ? prod[Y_W+ACC_BITS-1:ACC_BITS] : y_i;
				f_s[k] <= f_i;
				n_s[k] <= n_i;
			end
		end
	end

	// Integer part of the exponent is a right shift, then round to the output scale.
	always_comb begin
		ys   = y_s[RATIO_BITS] >> n_s[RATIO_BITS];
		rsum = {1'b0, ys} + ((Y_W+1)'(1) << (ACC_BITS - OUT_FRAC_BITS - 1));
		if (ctl_s[RATIO_BITS].forced) begin
			mem_n = ctl_s[RATIO_BITS].one ? ONE : '0;
		end else begin
			mem_n = rsum[ACC_BITS:ACC_BITS-OUT_FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_s <= 1'b0;
		end else if (en) begin
			vld_out_s <= ctl_s[RATIO_BITS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s <= mem_n;
		end
	end

	assign membership = out_s;
	assign out_vld    = vld_out_s;

	a_y_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[RATIO_BITS].vld |-> y_s[RATIO_BITS] <= (Y_W'(1) << ACC_BITS))
		else $error("power accumulator above one");

endmodule

@@ rtl/bell_membership_eval_core.sv @@
// Fuzzy membership evaluator: 0.5 ^ ((distance / width) ^ 2) of a sample against a centre.
// Input stream: s_axis_tdata carries the Q16.16 sample, s_axis_tuser the sample-valid flag.
// Output stream: m_axis_tdata carries the membership in Q1.15, where 0x8000 is exactly one.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high (0 centre,
// 1 centre-set flag, 2 left width, 3 right width, 4 curve mode); write only while the
// pipeline is empty.
// The pipeline holds 48 registers: three front stages (difference, magnitude, range check),
// 23 divider stages producing one ratio bit each, a squaring stage, 20 power stages with one
// multiplier each, and the rounding register. Throughput is one word per clock while the
// receiver takes the output.
// All stages advance together whenever the output register is empty or being taken. When
// the receiver stalls, the whole pipeline holds and one more input word is parked in an
// input skid register, so s_axis_tready is a register output.
// Reset clears all valid bits and loads the register defaults (centre unset, widths of
// 1000.0, two-sided mode); no words are in flight afterwards.
module bell_membership_eval_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bme_pkg::VAL_W-1:0]        s_axis_tdata,  // [31:0] env_value
	input  logic                             s_axis_tuser,  // [0] env_valid
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [bme_pkg::OUT_W-1:0]        m_axis_tdata,  // [15:0] membership
	input  logic                             cfg_we,
	input  logic [bme_pkg::ADDR_W-1:0]       cfg_addr,
	input  logic [bme_pkg::VAL_W-1:0]        cfg_wdata
);
	import bme_pkg::*;

	bme_cfg_t         cfg_q;
	logic             skid_vld_q;
	logic [VAL_W-1:0] skid_value_q;
	logic             skid_ok_q;
	logic             en;
	logic             take;
	logic             in_vld;
	logic [VAL_W-1:0] in_value;
	logic             in_ok;
	logic [VAL_W-1:0] distance;
	bme_ctl_t         ctl_front;
	logic [Q_W-1:0]   ratio;
	bme_ctl_t         ctl_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center    <= '0;
			cfg_q.center_ok <= 1'b0;
			cfg_q.wl        <= WIDTH_RST;
			cfg_q.wr        <= WIDTH_RST;
			cfg_q.mode      <= MODE_BELL;
		end else if (cfg_we) begin
			unique case (bme_reg_t'(cfg_addr))
				REG_CENTER:    cfg_q.center    <= cfg_wdata;
				REG_CENTER_OK: cfg_q.center_ok <= cfg_wdata[0];
				REG_LEFT_W:    cfg_q.wl        <= cfg_wdata[WID_W-1:0];
				REG_RIGHT_W:   cfg_q.wr        <= cfg_wdata[WID_W-1:0];
				REG_MODE:      cfg_q.mode      <= bme_mode_t'(cfg_wdata[1:0]);
				default: begin
				end
			endcase
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !skid_vld_q;
	assign take          = s_axis_tvalid && s_axis_tready;

	// A word that arrives while the pipeline holds waits in the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (take) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && take) begin
			skid_value_q <= s_axis_tdata;
			skid_ok_q    <= s_axis_tuser;
		end
	end

	always_comb begin
		in_vld   = skid_vld_q || take;
		in_value = skid_vld_q ? skid_value_q : s_axis_tdata;
		in_ok    = skid_vld_q ? skid_ok_q : s_axis_tuser;
	end

	bme_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_vld),
		.in_value (in_value),
		.in_ok    (in_ok),
		.cfg      (cfg_q),
		.distance (distance),
		.ctl      (ctl_front)
	);

	bme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.distance (distance),
		.ctl_in   (ctl_front),
		.ratio    (ratio),
		.ctl_out  (ctl_div)
	);

	bme_exp u_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ratio      (ratio),
		.ctl_in     (ctl_div),
		.membership (m_axis_tdata),
		.out_vld    (m_axis_tvalid)
	);

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= ONE)
		else $error("membership above one");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && en |=> !skid_vld_q)
		else $error("parked word not moved into the pipeline");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_vld_q && take && !en |=> skid_vld_q && !s_axis_tready)
		else $error("word accepted during a hold was not parked");

endmodule
